### rtl/svpc_pkg.sv
// Package: constants, codes and widths shared by the stepper velocity controller.
`default_nettype none
package svpc_pkg;
    localparam int WORD_W    = 32;
    localparam int MAG_W     = 42;
    localparam int PROD_W    = MAG_W + WORD_W;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = 29;
    localparam int RATE_W    = 29;
    localparam int PERIOD_W  = 18;
    localparam int ACC_W     = 44;
    localparam int CFG_IDX_W = 3;

    localparam logic [57:0] PRODUCT_CAP = 58'd1 << 40;
    localparam logic [NUM_W-1:0] PERIOD_NUMERATOR = 36'd65536000000;
    localparam logic [DEN_W-1:0] TICKS_PER_SECOND = 29'd200;
    localparam logic signed [33:0] INTEGRAL_LIMIT = 34'sd131072000;
    localparam logic signed [ACC_W-1:0] RATE_LIMIT = 44'sd262144000;
    localparam logic [27:0] STOP_LEVEL = 28'd327680;
    localparam logic signed [33:0] UPDATE_LEVEL = 34'sd65536;

    localparam logic [WORD_W-1:0] GAIN_P_RESET = 32'd131072000;
    localparam logic [WORD_W-1:0] GAIN_I_RESET = 32'd16384;
    localparam logic [WORD_W-1:0] GAIN_D_RESET = 32'd6554;

    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_ESTOP = 2'd1;

    localparam logic [1:0] ACT_LEAVE   = 2'd0;
    localparam logic [1:0] ACT_DISABLE = 2'd1;
    localparam logic [1:0] ACT_ENABLE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_M   = 3'd5;
endpackage
`default_nettype wire

### rtl/stepper_velocity_pid_control.sv
// Top level: wheel velocity PID with feedforward, step-rate clamp and period reload.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_mode, s_linear_speed_target, s_turn_rate_target,
//                                           s_measured_speed
//  m_       out        m_valid / m_ready    m_timer_action, m_direction, m_period_write,
//                                           m_step_period_us, m_step_rate
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Automatic mode: input transfer to result is set by five serial multiplies and one or two
// serial divides (speed error / 200, then the period when it is reloaded); other modes go
// straight from input transfer to the output register.
// One item in flight; the next is taken as soon as its result sits in the output register.
// Reset (aresetn low, synchronous) restores register defaults and clears PID state.
// m_ready low holds the result; s_ready stays low until that result can be stored.
`default_nettype none
module stepper_velocity_pid_control (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_mode,
    input  wire logic signed [svpc_pkg::WORD_W-1:0]   s_linear_speed_target,
    input  wire logic signed [svpc_pkg::WORD_W-1:0]   s_turn_rate_target,
    input  wire logic signed [svpc_pkg::WORD_W-1:0]   s_measured_speed,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [1:0]                                m_timer_action,
    output logic                                      m_direction,
    output logic                                      m_period_write,
    output logic [svpc_pkg::PERIOD_W-1:0]             m_step_period_us,
    output logic signed [svpc_pkg::RATE_W-1:0]        m_step_rate,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [svpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [svpc_pkg::WORD_W-1:0]          cfg_data
);
    import svpc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TURN, ST_ERR, ST_EDIV, ST_MGO, ST_MUL, ST_RATE, ST_DEC, ST_PDIV, ST_FIN
    } state_t;

    state_t state_reg;

    logic [WORD_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, half_base_reg, steps_m_reg;
    logic              side_reg;

    logic signed [WORD_W-1:0] err_int_reg, last_err_reg, last_rate_reg;
    logic signed [WORD_W-1:0] v_reg, meas_reg, tgt_reg, e_reg, integ_reg;
    logic signed [MAG_W-1:0]  d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [RATE_W-1:0] f_reg;
    logic [1:0]               idx_reg;

    logic [1:0]          res_action_reg;
    logic                res_dir_reg, res_pw_reg;
    logic [PERIOD_W-1:0] res_period_reg;

    logic                     mul_start_reg, mul_neg_reg, mul_done;
    logic [MAG_W-1:0]         mul_mag_reg;
    logic [WORD_W-1:0]        mul_gain_reg;
    logic signed [MAG_W-1:0]  mul_res;
    logic                     div_start_reg, div_done;
    logic [NUM_W-1:0]         div_num_reg, div_quo;
    logic [DEN_W-1:0]         div_den_reg;

    logic                     m_valid_reg;
    logic [1:0]               m_action_reg;
    logic                     m_dir_reg, m_pw_reg;
    logic [PERIOD_W-1:0]      m_period_reg;
    logic signed [RATE_W-1:0] m_rate_reg;

    logic signed [MAG_W-1:0]  w_ext, op_sel;
    logic [MAG_W-1:0]         w_mag, op_mag;
    logic signed [MAG_W:0]    tsum;
    logic signed [WORD_W-1:0] tgt_sat, e_sat, integ_new;
    logic signed [WORD_W:0]   ediff, ddiff, qs;
    logic [WORD_W-1:0]        e_mag;
    logic signed [33:0]       isum, rdiff;
    logic signed [MAG_W-1:0]  d_new;
    logic signed [ACC_W-1:0]  f_clamp;
    logic [27:0]              f_mag;

    svpc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg), .mag(mul_mag_reg),
        .neg(mul_neg_reg), .gain(mul_gain_reg), .done(mul_done), .result(mul_res)
    );

    svpc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg), .num(div_num_reg),
        .den(div_den_reg), .done(div_done), .quo(div_quo)
    );

    always_comb begin
        w_ext = MAG_W'(s_turn_rate_target);
        w_mag = w_ext[MAG_W-1] ? MAG_W'(-w_ext) : MAG_W'(w_ext);

        tsum = side_reg ? (MAG_W+1)'(v_reg) - (MAG_W+1)'(mul_res)
                        : (MAG_W+1)'(v_reg) + (MAG_W+1)'(mul_res);
        if (tsum > 43'sd2147483647)       tgt_sat = 32'sh7fffffff;
        else if (tsum < -43'sd2147483648) tgt_sat = 32'sh80000000;
        else                              tgt_sat = tsum[WORD_W-1:0];

        ediff = (WORD_W+1)'(tgt_reg) - (WORD_W+1)'(meas_reg);
        if (ediff > 33'sd2147483647)       e_sat = 32'sh7fffffff;
        else if (ediff < -33'sd2147483648) e_sat = 32'sh80000000;
        else                               e_sat = ediff[WORD_W-1:0];
        e_mag = e_sat[WORD_W-1] ? WORD_W'(-(WORD_W+1)'(e_sat)) : e_sat;

        qs = e_reg[WORD_W-1] ? -$signed({1'b0, div_quo[WORD_W-1:0]})
                             : $signed({1'b0, div_quo[WORD_W-1:0]});
        isum = 34'(err_int_reg) + 34'(qs);
        if (isum > INTEGRAL_LIMIT)       integ_new = WORD_W'(INTEGRAL_LIMIT);
        else if (isum < -INTEGRAL_LIMIT) integ_new = WORD_W'(-INTEGRAL_LIMIT);
        else                             integ_new = isum[WORD_W-1:0];
        ddiff = (WORD_W+1)'(e_reg) - (WORD_W+1)'(last_err_reg);
        d_new = (MAG_W'(ddiff) <<< 7) + (MAG_W'(ddiff) <<< 6) + (MAG_W'(ddiff) <<< 3);

        case (idx_reg)
            2'd0:    op_sel = MAG_W'(tgt_reg);
            2'd1:    op_sel = MAG_W'(e_reg);
            2'd2:    op_sel = MAG_W'(integ_reg);
            default: op_sel = d_reg;
        endcase
        op_mag = op_sel[MAG_W-1] ? MAG_W'(-op_sel) : MAG_W'(op_sel);

        if (acc_reg > RATE_LIMIT)       f_clamp = RATE_LIMIT;
        else if (acc_reg < -RATE_LIMIT) f_clamp = -RATE_LIMIT;
        else                            f_clamp = acc_reg;

        f_mag = f_reg[RATE_W-1] ? 28'(-f_reg) : 28'(f_reg);
        rdiff = 34'(last_rate_reg) - 34'(f_reg);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_timer_action   = m_action_reg;
    assign m_direction      = m_dir_reg;
    assign m_period_write   = m_pw_reg;
    assign m_step_period_us = m_period_reg;
    assign m_step_rate      = m_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
            side_reg      <= 1'b0;
            half_base_reg <= '0;
            steps_m_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_SIDE:      side_reg      <= cfg_data[0];
                REG_HALF_BASE: half_base_reg <= cfg_data;
                REG_STEPS_M:   steps_m_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            err_int_reg   <= '0;
            last_err_reg  <= '0;
            last_rate_reg <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        v_reg          <= s_linear_speed_target;
                        meas_reg       <= s_measured_speed;
                        res_dir_reg    <= 1'b0;
                        res_pw_reg     <= 1'b0;
                        res_period_reg <= '0;
                        f_reg          <= '0;
                        if (s_mode == MODE_AUTO) begin
                            mul_mag_reg   <= w_mag;
                            mul_neg_reg   <= w_ext[MAG_W-1];
                            mul_gain_reg  <= half_base_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_TURN;
                        end else begin
                            res_action_reg <= (s_mode == MODE_ESTOP) ? ACT_DISABLE : ACT_LEAVE;
                            state_reg      <= ST_FIN;
                        end
                    end
                end
                ST_TURN: begin
                    if (mul_done) begin
                        tgt_reg   <= tgt_sat;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    e_reg         <= e_sat;
                    div_num_reg   <= NUM_W'(e_mag);
                    div_den_reg   <= TICKS_PER_SECOND;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_EDIV;
                end
                ST_EDIV: begin
                    if (div_done) begin
                        integ_reg    <= integ_new;
                        err_int_reg  <= integ_new;
                        last_err_reg <= e_reg;
                        d_reg        <= d_new;
                        acc_reg      <= '0;
                        idx_reg      <= '0;
                        state_reg    <= ST_MGO;
                    end
                end
                ST_MGO: begin
                    mul_mag_reg <= op_mag;
                    mul_neg_reg <= op_sel[MAG_W-1];
                    case (idx_reg)
                        2'd0:    mul_gain_reg <= steps_m_reg;
                        2'd1:    mul_gain_reg <= gain_p_reg;
                        2'd2:    mul_gain_reg <= gain_i_reg;
                        default: mul_gain_reg <= gain_d_reg;
                    endcase
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL;
                end
                ST_MUL: begin
                    if (mul_done) begin
                        acc_reg <= acc_reg + ACC_W'(mul_res);
                        if (idx_reg == 2'd3) begin
                            state_reg <= ST_RATE;
                        end else begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_MGO;
                        end
                    end
                end
                ST_RATE: begin
                    f_reg     <= f_clamp[RATE_W-1:0];
                    state_reg <= ST_DEC;
                end
                ST_DEC: begin
                    if (f_mag < STOP_LEVEL) begin
                        res_action_reg <= ACT_DISABLE;
                        err_int_reg    <= '0;
                        last_err_reg   <= '0;
                        state_reg      <= ST_FIN;
                    end else begin
                        res_action_reg <= ACT_ENABLE;
                        res_dir_reg    <= f_reg[RATE_W-1];
                        if (rdiff > UPDATE_LEVEL || rdiff < -UPDATE_LEVEL) begin
                            last_rate_reg <= WORD_W'(f_reg);
                            res_pw_reg    <= 1'b1;
                            div_num_reg   <= PERIOD_NUMERATOR;
                            div_den_reg   <= DEN_W'(f_mag);
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_PDIV;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_PDIV: begin
                    if (div_done) begin
                        res_period_reg <= div_quo[PERIOD_W-1:0];
                        state_reg      <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_action_reg <= res_action_reg;
                        m_dir_reg    <= res_dir_reg;
                        m_pw_reg     <= res_pw_reg;
                        m_period_reg <= res_period_reg;
                        m_rate_reg   <= f_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_pw_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_period_write) |-> (m_timer_action == ACT_ENABLE))
        else $error("period write without timer enable");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timer_action != ACT_ENABLE) |-> (!m_direction && !m_period_write))
        else $error("direction or period write while timer not enabled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_start_reg && div_start_reg))
        else $error("multiplier and divider started together");
endmodule
`default_nettype wire

### rtl/svpc_mul.sv
// Bit-serial gain multiplier: (|a| * g) >> 16, capped at 2^40, sign applied.
`default_nettype none
module svpc_mul (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [svpc_pkg::MAG_W-1:0]         mag,
    input  wire logic                               neg,
    input  wire logic [svpc_pkg::WORD_W-1:0]        gain,
    output logic                                    done,
    output logic signed [svpc_pkg::MAG_W-1:0]       result
);
    import svpc_pkg::*;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  mcand_reg;
    logic              neg_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MAG_W:0]    sum;
    logic [57:0]       shifted;
    logic [40:0]       capped;

    always_comb begin
        sum = {1'b0, prod_reg[PROD_W-1:WORD_W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {sum, prod_reg[WORD_W-1:1]};
        shifted = prod_reg[PROD_W-1:16];
        capped = (shifted > PRODUCT_CAP) ? PRODUCT_CAP[40:0] : shifted[40:0];
        result = neg_reg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                prod_reg  <= {{MAG_W{1'b0}}, gain};
                mcand_reg <= mag;
                neg_reg   <= neg;
            end else if (busy_reg) begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/svpc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module svpc_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [svpc_pkg::NUM_W-1:0]   num,
    input  wire logic [svpc_pkg::DEN_W-1:0]   den,
    output logic                              done,
    output logic [svpc_pkg::NUM_W-1:0]        quo
);
    import svpc_pkg::*;

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        ge    = !diff[DEN_W+1];
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                q_reg   <= {q_reg[NUM_W-2:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the stepper velocity PID controller: random and directed ticks, scoreboard.
module tb;
    import svpc_pkg::*;

    localparam logic [1:0] MODE_OTHER  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint CAP = 64'd1 << 40;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] lin;
        logic signed [31:0] turn;
        logic signed [31:0] meas;
    } tick_t;

    typedef struct {
        logic [1:0]  action;
        logic        dir;
        logic        pw;
        logic [17:0] period;
        logic [28:0] rate;
    } cmd_t;

    class wheel_scoreboard;
        logic [31:0] kp, ki, kd, hwb, spm;
        logic        side;
        int          integ_st, last_err, last_rate;
        cmd_t        pending_cmds[$];
        int          fails;

        function new();
            kp = GAIN_P_RESET; ki = GAIN_I_RESET; kd = GAIN_D_RESET;
            side = 0; hwb = 0; spm = 0;
            integ_st = 0; last_err = 0; last_rate = 0; fails = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_GAIN_P:    kp = val;
                REG_GAIN_I:    ki = val;
                REG_GAIN_D:    kd = val;
                REG_SIDE:      side = val[0];
                REG_HALF_BASE: hwb = val;
                REG_STEPS_M:   spm = val;
                default: ;
            endcase
        endfunction

        static function longint scale(longint a, logic [31:0] g);
            logic [63:0] mag;
            logic [95:0] prod;
            logic [63:0] r;
            mag = (a < 0) ? -a : a;
            prod = {32'd0, mag} * {64'd0, g};
            if (prod[95:64] != 0) r = CAP;
            else begin
                r = prod[79:16];
                if (r > CAP) r = CAP;
            end
            return (a < 0) ? -longint'(r) : longint'(r);
        endfunction

        static function longint clip(longint x, longint lo, longint hi);
            return (x < lo) ? lo : (x > hi) ? hi : x;
        endfunction

        function void note_tick(tick_t t);
            cmd_t   c;
            longint tw, tgt, ff, e, integ, d, f, mag, diff;
            c = '{default: '0};
            f = 0;
            if (t.mode == MODE_AUTO) begin
                tw = scale(longint'(t.turn), hwb);
                tgt = side ? longint'(t.lin) - tw : longint'(t.lin) + tw;
                tgt = clip(tgt, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
                ff = scale(tgt, spm);
                e = clip(tgt - longint'(t.meas), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
                integ = clip(longint'(integ_st) + e / 200, -131072000, 131072000);
                d = (e - longint'(last_err)) * 200;
                integ_st = int'(integ);
                last_err = int'(e);
                f = ff + scale(e, kp) + scale(integ, ki) + scale(d, kd);
                f = clip(f, -262144000, 262144000);
                mag = (f < 0) ? -f : f;
                if (mag < 327680) begin
                    c.action = ACT_DISABLE;
                    integ_st = 0;
                    last_err = 0;
                end else begin
                    diff = longint'(last_rate) - f;
                    c.action = ACT_ENABLE;
                    c.dir = (f < 0);
                    if (diff > 65536 || diff < -65536) begin
                        last_rate = int'(f);
                        c.pw = 1;
                        c.period = 18'(64'sd65536000000 / mag);
                    end
                end
            end else if (t.mode == MODE_ESTOP) begin
                c.action = ACT_DISABLE;
            end
            c.rate = 29'(f);
            pending_cmds.push_back(c);
        endfunction

        function void check_cmd(cmd_t got);
            cmd_t x;
            if (pending_cmds.size() == 0) begin
                $error("result transfer with nothing expected");
                fails++;
                return;
            end
            x = pending_cmds.pop_front();
            if (got.action !== x.action) begin
                $error("timer_action exp %0d got %0d", x.action, got.action); fails++;
            end
            if (got.dir !== x.dir) begin
                $error("direction exp %0d got %0d", x.dir, got.dir); fails++;
            end
            if (got.pw !== x.pw) begin
                $error("period_write exp %0d got %0d", x.pw, got.pw); fails++;
            end
            if (got.period !== x.period) begin
                $error("step_period_us exp %0d got %0d", x.period, got.period); fails++;
            end
            if (got.rate !== x.rate) begin
                $error("step_rate exp %h got %h", x.rate, got.rate); fails++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic signed [31:0] s_linear_speed_target = '0;
    logic signed [31:0] s_turn_rate_target = '0;
    logic signed [31:0] s_measured_speed = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_timer_action;
    logic        m_direction;
    logic        m_period_write;
    logic [PERIOD_W-1:0] m_step_period_us;
    logic signed [RATE_W-1:0] m_step_rate;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    wheel_scoreboard sb = new();
    bit   quiet = 0;
    bit   hold_req = 0;
    tick_t prev;

    stepper_velocity_pid_control u_top (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    initial begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int gap_len();
        if (quiet) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 60);
    endfunction

    // receiver
    initial begin
        int rx_gap;
        rx_gap = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
            end
            if (rx_gap > 0) begin
                m_ready = 0;
                rx_gap--;
            end else begin
                m_ready = 1;
                if ($urandom_range(0, 99) < 15) rx_gap = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_cmd('{m_timer_action, m_direction, m_period_write,
                           m_step_period_us, m_step_rate});
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_tick(tick_t t);
        int g;
        s_valid = 1;
        s_mode = t.mode;
        s_linear_speed_target = t.lin;
        s_turn_rate_target = t.turn;
        s_measured_speed = t.meas;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t);
        prev = t;
        @(negedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_valid = 0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 0;
        while (sb.pending_cmds.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && prev.mode == MODE_AUTO) begin
            t = prev;
            if ($urandom_range(0, 1)) t.meas = t.meas + 32'($urandom_range(0, 64)) - 32;
            return t;
        end
        t.lin = rand_word();
        t.turn = rand_word();
        t.meas = ($urandom_range(0, 2) == 0) ? rand_word()
                                             : t.lin + 32'($urandom_range(0, 4096)) - 2048;
        case ($urandom_range(0, 19))
            0: t.mode = MODE_ESTOP;
            1: t.mode = MODE_OTHER;
            2: t.mode = MODE_UNUSED;
            default: t.mode = MODE_AUTO;
        endcase
        return t;
    endfunction

    task automatic set_phase(int p);
        logic [31:0] v[6];
        if (p == 1) v = '{0, 0, 0, 0, 0, 0};
        else if (p == 2) v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF};
        else if (p == 5) v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else v = '{$urandom_range(0, 1 << 26), $urandom_range(0, 1 << 18),
                   $urandom_range(0, 1 << 16), $urandom_range(0, 1),
                   $urandom_range(0, 1 << 15), $urandom_range(0, 1 << 28)};
        write_reg(REG_GAIN_P, v[0]);
        write_reg(REG_GAIN_I, v[1]);
        write_reg(REG_GAIN_D, v[2]);
        write_reg(REG_SIDE, v[3]);
        write_reg(REG_HALF_BASE, v[4]);
        write_reg(REG_STEPS_M, v[5]);
    endtask

    initial begin
        tick_t dir_ticks[$];
        prev = '{MODE_OTHER, 0, 0, 0};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // reset config: gain_p 2000, no feedforward; error steps around the stop band
        dir_ticks = '{
            '{MODE_ESTOP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
            '{MODE_OTHER, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0},
            '{MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{MODE_AUTO, 0, 0, 0},
            '{MODE_AUTO, 65536, 0, 0},
            '{MODE_AUTO, 65536, 0, 0},
            '{MODE_AUTO, -65536, 0, 0},
            '{MODE_AUTO, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
            '{MODE_AUTO, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            '{MODE_AUTO, 1, 0, 0},
            '{MODE_AUTO, 200, 0, 0},
            '{MODE_AUTO, -200, 0, 0},
            '{MODE_AUTO, 164, 0, 0},
            '{MODE_AUTO, 163, 0, 0},
            '{MODE_AUTO, 164, 0, 0},
            '{MODE_ESTOP, 0, 0, 0},
            '{MODE_AUTO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
        };
        foreach (dir_ticks[i]) send_tick(dir_ticks[i]);
        drain();

        for (int p = 1; p <= 8; p++) begin
            set_phase(p);
            quiet = (p % 3 == 0);
            if (p == 4) hold_req = 1;
            repeat (140) send_tick(rand_tick());
            drain();
        end

        if (sb.fails == 0 && sb.pending_cmds.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
rtl/svpc_pkg.sv
rtl/svpc_mul.sv
rtl/svpc_div.sv
rtl/stepper_velocity_pid_control.sv
test/tb.sv
